>>> rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

	localparam int TIME_W = 21;
	localparam int VAL_W  = 16;
	localparam int NUM_W  = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = 21'h1F_FFFF;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic                    op;
		logic [VAL_W-1:0]        arrival_time;
		logic [VAL_W-1:0]        burst_length;
		logic signed [VAL_W-1:0] priority_level;
	} in_word_t;

	typedef struct packed {
		logic [NUM_W-1:0]  running_task;
		logic              task_finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              all_finished;
		logic [TIME_W-1:0] now;
		logic              load_rejected;
	} out_word_t;

	// one table row as stored in the task RAM
	typedef struct packed {
		logic [VAL_W-1:0]        arrival;
		logic [VAL_W-1:0]        burst;
		logic signed [VAL_W-1:0] prio;
		logic [VAL_W-1:0]        remain;
	} task_entry_t;

	typedef struct packed {
		logic capture;     // latch the accepted input word
		logic scan_start;  // clear scan index and best candidate
		logic scan_step;   // read the next table row
		logic commit;      // write back, update counters, load output register
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;   // every loaded row has been read
		logic out_free;    // output register can take a word this cycle
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/pps_ram.sv
`default_nettype none

module pps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pps_ctrl.sv
`default_nettype none

module pps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_op,
	output logic                   in_ready,
	input  wire pps_pkg::dp_stat_t stat,
	output pps_pkg::dp_cmd_t       cmd
);

	import pps_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture    = 1'b1;
					cmd.scan_start = (in_op == OP_TICK);
					state_d        = (in_op == OP_TICK) ? ST_SCAN : ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (!stat.scan_done) begin
					cmd.scan_step = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// the last row read was already compared in ST_SCAN; this state only waits
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pps_datapath.sv
`default_nettype none

module pps_datapath #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pps_pkg::in_word_t in_data,
	input  wire pps_pkg::dp_cmd_t  cmd,
	output pps_pkg::dp_stat_t      stat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pps_pkg::out_word_t     out_data
);

	import pps_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int IW = $clog2(MAX_TASKS);
	localparam int EW = $bits(task_entry_t);

	in_word_t                in_q;
	logic [CW-1:0]           task_count_q;
	logic [CW-1:0]           fin_count_q;
	logic [TIME_W-1:0]       cur_time_q;
	logic                    started_q;

	logic [CW-1:0]           idx_q;
	logic                    rd_valid_s1;
	logic [IW-1:0]           rd_idx_s1;
	logic                    found_q;
	logic [IW-1:0]           best_idx_q;
	logic [VAL_W-1:0]        best_arr_q;
	logic [VAL_W-1:0]        best_bur_q;
	logic signed [VAL_W-1:0] best_pri_q;
	logic [VAL_W-1:0]        best_rem_q;

	logic                    out_valid_q;
	out_word_t               out_q;

	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	task_entry_t             ram_wentry;
	logic [EW-1:0]           ram_rdata;
	task_entry_t             rd_entry;

	logic                    is_tick;
	logic                    rd_ready;
	logic                    rd_better;
	logic                    load_ok;
	logic                    finish;
	logic [TIME_W-1:0]       next_time;
	logic [TIME_W-1:0]       tat;
	logic [TIME_W-1:0]       wait_t;
	logic [CW-1:0]           task_count_d;
	logic [CW-1:0]           fin_count_d;
	out_word_t               result;

	pps_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_TASKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.re   (cmd.scan_step),
		.raddr(idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_entry = task_entry_t'(ram_rdata);
	assign is_tick  = (in_q.op == OP_TICK);

	assign stat.scan_done = (idx_q == task_count_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	// candidate compare on the row read last cycle
	assign rd_ready  = (TIME_W'(rd_entry.arrival) <= cur_time_q) && (rd_entry.remain != '0);
	assign rd_better = !found_q || ($signed(rd_entry.prio) > $signed(best_pri_q));

	assign load_ok = !started_q && (task_count_q != CW'(MAX_TASKS))
		&& (in_q.burst_length != '0);

	assign next_time = (cur_time_q < TIME_MAX) ? cur_time_q + TIME_W'(1) : cur_time_q;
	assign finish    = is_tick && found_q && (best_rem_q == VAL_W'(1));
	assign tat       = (next_time > TIME_W'(best_arr_q)) ? next_time - TIME_W'(best_arr_q) : '0;
	assign wait_t    = (tat > TIME_W'(best_bur_q)) ? tat - TIME_W'(best_bur_q) : '0;

	always_comb begin
		task_count_d = task_count_q;
		fin_count_d  = fin_count_q;
		ram_we       = 1'b0;
		ram_waddr    = best_idx_q;
		ram_wentry   = '{arrival: best_arr_q, burst: best_bur_q, prio: best_pri_q,
			remain: best_rem_q - VAL_W'(1)};
		result       = '0;
		if (is_tick) begin
			ram_we = cmd.commit && found_q;
			if (finish) begin
				fin_count_d          = fin_count_q + CW'(1);
				result.task_finished = 1'b1;
				result.turnaround    = tat;
				result.waiting       = wait_t;
			end
			if (found_q) begin
				result.running_task = NUM_W'(CW'(best_idx_q) + CW'(1));
			end
			result.now = next_time;
		end else begin
			ram_waddr  = task_count_q[IW-1:0];
			ram_wentry = '{arrival: in_q.arrival_time, burst: in_q.burst_length,
				prio: in_q.priority_level, remain: in_q.burst_length};
			ram_we     = cmd.commit && load_ok;
			if (load_ok) begin
				task_count_d = task_count_q + CW'(1);
			end
			result.load_rejected = !load_ok;
			result.now           = cur_time_q;
		end
		result.all_finished = (fin_count_d == task_count_d);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			fin_count_q  <= '0;
			cur_time_q   <= '0;
			started_q    <= 1'b0;
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + CW'(1);
			end
			if (rd_valid_s1 && rd_ready && rd_better) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				task_count_q <= task_count_d;
				fin_count_q  <= fin_count_d;
				cur_time_q   <= result.now;
				if (is_tick) begin
					started_q <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.scan_step) begin
			rd_idx_s1 <= idx_q[IW-1:0];
		end
		if (rd_valid_s1 && rd_ready && rd_better) begin
			best_idx_q <= rd_idx_s1;
			best_arr_q <= rd_entry.arrival;
			best_bur_q <= rd_entry.burst;
			best_pri_q <= rd_entry.prio;
			best_rem_q <= rd_entry.remain;
		end
		if (cmd.commit) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler.
// Input channel (in_valid / in_ready / in_data): each word is either a load,
// which appends one task (arrival, burst, signed priority) to the table unless
// rejected, or a tick, which serves one time unit. Output channel (out_valid /
// out_ready / out_data): exactly one word per input word, in order.
// On a tick the table is read one row per cycle from the task RAM; the
// arrived, unfinished row with the highest priority wins, lowest slot on a
// tie. A tick passes from acceptance through the scan, drain and commit
// steps; a load goes straight to its commit step. The row-by-row RAM scan
// makes a tick take longer as more tasks are loaded.
// One item is in work at a time; in_ready is high only while the controller
// is idle. The output register holds a finished word, so the next input word
// is accepted while the previous result still waits for out_ready; a new
// result stalls in its commit step only while that register is still full.
// Reset clears the task count, finished count, time and started flag; the
// table RAM is not cleared, since only loaded rows are ever read.
`default_nettype none

module preemptive_priority_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pps_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pps_pkg::out_word_t      out_data
);

	import pps_pkg::*;

	// command and status between the sequencer and the datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: idle, scan the table, drain, commit
	pps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (in_data.op),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// table RAM, best-candidate registers, counters, time and output register
	pps_datapath #(
		.MAX_TASKS(MAX_TASKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

>>> rtl/pps_checker.sv
`default_nettype none

module pps_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire pps_pkg::in_word_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire pps_pkg::out_word_t out_data
);

	import pps_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice back to back");

	a_reject_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.load_rejected |->
			out_data.running_task == '0 && !out_data.task_finished)
		else $error("rejected load reports service");

	a_times_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.task_finished |->
			out_data.turnaround == '0 && out_data.waiting == '0)
		else $error("times reported without completion");

	a_wait_le_tat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.waiting <= out_data.turnaround)
		else $error("waiting exceeds turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire
